@@ rtl/core/vsm_pkg.sv @@
// Package for the vector softmax unit: sizes, exponent base factor, state enum.
// Used by vsm_ctrl, vsm_datapath and vector_softmax_unit.
package vsm_pkg;
  localparam int MAX_LEN = 32;
  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [31:0] EXP_F0 = 32'd4293918848;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RD, ST_EXP_INIT, ST_EXP_MUL, ST_EXP_ACC,
    ST_EMIT_RD, ST_EXP2_INIT, ST_EXP2_MUL, ST_DIV_INIT, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic exp_init;
    logic exp_step;
    logic acc;
    logic div_init;
    logic div_step;
    logic emit;
    logic clr;
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic exp_done;
    logic div_done;
    logic idx_last;
    logic empty;
  } stat_t;
endpackage

@@ rtl/core/vector_softmax_unit.sv @@
// Top level of the vector softmax unit: joins vsm_ctrl and vsm_datapath.
// Depends on vsm_pkg, vsm_ctrl, vsm_datapath.
//
//  channel | handshake        | payload
//  input   | start / busy     | value[15:0] signed, last
//  result  | out_valid strobe | prob[15:0], last_out
//
// Loading accepts one element per cycle while busy is low. After the last element,
// each stored element goes through a 16-step serial exponent multiply in the sum
// pass, and through the exponent again plus a 42-step restoring divider in the emit pass.
// busy is high from the last element until the final result. Reset is
// synchronous on rst; the receiver cannot stall results.
module vector_softmax_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] value,
  input  logic        last,
  output logic        out_valid,
  output logic [15:0] prob,
  output logic        last_out
);
  vsm_pkg::cmd_t cmd;
  vsm_pkg::stat_t stat;
  logic last_flag;

  vsm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last(last), .busy(busy),
    .stat(stat), .cmd(cmd), .last_flag(last_flag)
  );

  vsm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .value($signed(value)), .prob(prob)
  );

  assign out_valid = cmd.emit;
  assign last_out = cmd.emit & last_flag;
endmodule

@@ rtl/core/vsm_datapath.sv @@
// Datapath of the vector softmax unit: element buffer, max, serial exponent, divider.
// Depends on vsm_pkg.
module vsm_datapath (
  input  logic               clk,
  input  logic               rst,
  input  vsm_pkg::cmd_t      cmd,
  output vsm_pkg::stat_t     stat,
  input  logic signed [15:0] value,
  output logic [15:0]        prob
);
  logic [15:0] mem [vsm_pkg::MAX_LEN];
  logic [vsm_pkg::CW-1:0] count;
  logic [vsm_pkg::AW-1:0] idx;
  logic signed [15:0] running_max;
  logic [31:0] exp_sum;
  logic signed [15:0] rd_data;
  logic [15:0] k;
  logic [3:0] bit_idx;
  logic [32:0] r;
  logic [31:0] f;
  logic [24:0] e_val;
  logic [63:0] prod;
  logic [63:0] sq;
  logic [32:0] r_rnd;
  logic [41:0] num;
  logic [41:0] q_acc;
  logic [41:0] r_acc;
  logic [41:0] r_sh;
  logic [5:0] dc;

  assign prod = r * f + 64'h80000000;
  assign sq = f * f + 64'h80000000;
  assign r_rnd = r + 33'd128;
  assign e_val = r_rnd[32:8];
  assign num = {1'b0, e_val, 16'd0} + {10'd0, exp_sum >> 1};
  assign r_sh = {r_acc[40:0], q_acc[41]};

  always_ff @(posedge clk) begin
    if (cmd.load && count != vsm_pkg::CW'(vsm_pkg::MAX_LEN))
      mem[count[vsm_pkg::AW-1:0]] <= value;
    if (cmd.rd) rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      count <= '0;
      running_max <= 16'sh8000;
      exp_sum <= '0;
    end else begin
      if (cmd.load && count != vsm_pkg::CW'(vsm_pkg::MAX_LEN)) begin
        count <= count + 1'b1;
        if (value > running_max) running_max <= value;
      end
      if (cmd.acc) exp_sum <= exp_sum + {7'd0, e_val};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.idx_clr) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_init) begin
      k <= 16'(running_max - rd_data);
      bit_idx <= '0;
      r <= 33'h100000000;
      f <= vsm_pkg::EXP_F0;
    end else if (cmd.exp_step) begin
      if (k[0]) r <= {1'b0, prod[63:32]};
      f <= sq[63:32];
      k <= k >> 1;
      bit_idx <= bit_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      q_acc <= num;
      r_acc <= '0;
      dc <= '0;
    end else if (cmd.div_step) begin
      dc <= dc + 1'b1;
      if (r_sh >= {10'd0, exp_sum}) begin
        r_acc <= r_sh - {10'd0, exp_sum};
        q_acc <= {q_acc[40:0], 1'b1};
      end else begin
        r_acc <= r_sh;
        q_acc <= {q_acc[40:0], 1'b0};
      end
    end
  end

  assign prob = (|q_acc[41:16]) ? 16'hFFFF : q_acc[15:0];

  assign stat.exp_done = (bit_idx == 4'd15);
  assign stat.div_done = (dc == 6'd41);
  assign stat.idx_last = ({1'b0, idx} == vsm_pkg::CW'(count - 1'b1));
  assign stat.empty = (count == '0);
endmodule

@@ rtl/core/vsm_ctrl.sv @@
// Controller of the vector softmax unit: sequences load, sum pass and emit pass.
// Depends on vsm_pkg.
module vsm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last,
  output logic           busy,
  input  vsm_pkg::stat_t stat,
  output vsm_pkg::cmd_t  cmd,
  output logic           last_flag
);
  vsm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= vsm_pkg::ST_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != vsm_pkg::ST_LOAD);
    last_flag = stat.idx_last;
    case (state)
      vsm_pkg::ST_LOAD: begin
        cmd.idx_clr = 1'b1;
        if (start) begin
          cmd.load = 1'b1;
          if (last) state_next = vsm_pkg::ST_RD;
        end
      end
      vsm_pkg::ST_RD: begin
        if (stat.empty) begin
          cmd.clr = 1'b1;
          state_next = vsm_pkg::ST_LOAD;
        end else begin
          cmd.rd = 1'b1;
          state_next = vsm_pkg::ST_EXP_INIT;
        end
      end
      vsm_pkg::ST_EXP_INIT: begin
        cmd.exp_init = 1'b1;
        state_next = vsm_pkg::ST_EXP_MUL;
      end
      vsm_pkg::ST_EXP_MUL: begin
        cmd.exp_step = 1'b1;
        if (stat.exp_done) state_next = vsm_pkg::ST_EXP_ACC;
      end
      vsm_pkg::ST_EXP_ACC: begin
        cmd.acc = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next = vsm_pkg::ST_EMIT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = vsm_pkg::ST_RD;
        end
      end
      vsm_pkg::ST_EMIT_RD: begin
        cmd.rd = 1'b1;
        state_next = vsm_pkg::ST_EXP2_INIT;
      end
      vsm_pkg::ST_EXP2_INIT: begin
        cmd.exp_init = 1'b1;
        state_next = vsm_pkg::ST_EXP2_MUL;
      end
      vsm_pkg::ST_EXP2_MUL: begin
        cmd.exp_step = 1'b1;
        if (stat.exp_done) state_next = vsm_pkg::ST_DIV_INIT;
      end
      vsm_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next = vsm_pkg::ST_DIV;
      end
      vsm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = vsm_pkg::ST_OUT;
      end
      vsm_pkg::ST_OUT: begin
        cmd.emit = 1'b1;
        if (stat.idx_last) begin
          cmd.clr = 1'b1;
          state_next = vsm_pkg::ST_LOAD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = vsm_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = vsm_pkg::ST_LOAD;
    endcase
  end
endmodule
